// ----- hdl/slbc_pkg.sv -----
// slbc_pkg: shared types, widths and codes for the status led blink coder
// no dependencies
`default_nettype none

package slbc_pkg;

  localparam int TIME_BITS  = 16;
  localparam int BLINK_BITS = 4;

  localparam int CFG_IDX_BITS  = 3;
  localparam int CFG_DATA_BITS = 16;

  // error class codes
  localparam logic [1:0] CLASS_NONE     = 2'd0;
  localparam logic [1:0] CLASS_FAULT    = 2'd1;
  localparam logic [1:0] CLASS_CRITICAL = 2'd2;

  // register indexes
  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_OK_BLINKS    = 3'd0,
    REG_OK_ON_MS     = 3'd1,
    REG_OK_OFF_MS    = 3'd2,
    REG_FAULT_BLINKS = 3'd3,
    REG_FAULT_ON_MS  = 3'd4,
    REG_FAULT_OFF_MS = 3'd5,
    REG_PERIOD_MS    = 3'd6
  } reg_idx_t;

  // register reset values
  localparam logic [3:0]  RST_OK_BLINKS    = 4'd1;
  localparam logic [15:0] RST_OK_ON_MS     = 16'd100;
  localparam logic [15:0] RST_OK_OFF_MS    = 16'd1900;
  localparam logic [3:0]  RST_FAULT_BLINKS = 4'd4;
  localparam logic [15:0] RST_FAULT_ON_MS  = 16'd150;
  localparam logic [15:0] RST_FAULT_OFF_MS = 16'd150;
  localparam logic [15:0] RST_PERIOD_MS    = 16'd2000;

  typedef struct packed {
    logic [3:0]  ok_blinks;
    logic [15:0] ok_on_ms;
    logic [15:0] ok_off_ms;
    logic [3:0]  fault_blinks;
    logic [15:0] fault_on_ms;
    logic [15:0] fault_off_ms;
    logic [15:0] period_ms;
  } cfg_t;

  // one tick's outcome from the core
  typedef struct packed {
    logic led_lit;
    logic burst_active;
  } result_t;

endpackage

`default_nettype wire

// ----- hdl/slbc_regs.sv -----
// slbc_regs: configuration register file of the blink coder
// depends on slbc_pkg
`default_nettype none

module slbc_regs (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              wr_en,
  input  wire logic [slbc_pkg::CFG_IDX_BITS-1:0]  wr_idx,
  input  wire logic [slbc_pkg::CFG_DATA_BITS-1:0] wr_data,
  output slbc_pkg::cfg_t                         cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.ok_blinks    <= slbc_pkg::RST_OK_BLINKS;
      cfg.ok_on_ms     <= slbc_pkg::RST_OK_ON_MS;
      cfg.ok_off_ms    <= slbc_pkg::RST_OK_OFF_MS;
      cfg.fault_blinks <= slbc_pkg::RST_FAULT_BLINKS;
      cfg.fault_on_ms  <= slbc_pkg::RST_FAULT_ON_MS;
      cfg.fault_off_ms <= slbc_pkg::RST_FAULT_OFF_MS;
      cfg.period_ms    <= slbc_pkg::RST_PERIOD_MS;
    end else if (wr_en) begin
      unique case (wr_idx)
        slbc_pkg::REG_OK_BLINKS:    cfg.ok_blinks    <= wr_data[3:0];
        slbc_pkg::REG_OK_ON_MS:     cfg.ok_on_ms     <= wr_data;
        slbc_pkg::REG_OK_OFF_MS:    cfg.ok_off_ms    <= wr_data;
        slbc_pkg::REG_FAULT_BLINKS: cfg.fault_blinks <= wr_data[3:0];
        slbc_pkg::REG_FAULT_ON_MS:  cfg.fault_on_ms  <= wr_data;
        slbc_pkg::REG_FAULT_OFF_MS: cfg.fault_off_ms <= wr_data;
        slbc_pkg::REG_PERIOD_MS:    cfg.period_ms    <= wr_data;
        default: ;  // unused index, write dropped
      endcase
    end
  end

endmodule

`default_nettype wire

// ----- hdl/slbc_core.sv -----
// slbc_core: blink sequencing state and its per-tick update
// depends on slbc_pkg
`default_nettype none

module slbc_core (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       step,
  input  wire logic [1:0] error_class,
  input  wire slbc_pkg::cfg_t cfg,
  output slbc_pkg::result_t res_next
);

  localparam int TB = slbc_pkg::TIME_BITS;
  localparam int BB = slbc_pkg::BLINK_BITS;
  localparam logic [TB-1:0] TIME_MAX = {TB{1'b1}};

  logic [TB-1:0] since_burst_start, since_burst_start_next;
  logic [TB-1:0] toggle_countdown, toggle_countdown_next;
  logic [BB-1:0] blinks_done, blinks_done_next;
  logic [BB-1:0] blinks_goal, blinks_goal_next;
  logic          phase_lit, phase_lit_next;
  logic          led_drive, led_drive_next;

  logic          healthy;
  logic [BB-1:0] sel_blinks;
  logic [TB-1:0] sel_on, sel_off, per, since_inc, cd_dec;
  logic [BB-1:0] done_inc;
  logic          ph_flip;

  always_comb begin
    healthy    = (error_class == slbc_pkg::CLASS_NONE);
    sel_blinks = BB'(healthy ? cfg.ok_blinks : cfg.fault_blinks);
    sel_on     = TB'(healthy ? cfg.ok_on_ms  : cfg.fault_on_ms);
    sel_off    = TB'(healthy ? cfg.ok_off_ms : cfg.fault_off_ms);
    per        = TB'(cfg.period_ms);

    since_inc = (since_burst_start < TIME_MAX) ? since_burst_start + 1'b1
                                               : since_burst_start;
    cd_dec    = (toggle_countdown != '0) ? toggle_countdown - 1'b1 : toggle_countdown;
    ph_flip   = ~phase_lit;
    done_inc  = ph_flip ? blinks_done : blinks_done + 1'b1;

    since_burst_start_next = since_inc;
    toggle_countdown_next  = toggle_countdown;
    blinks_done_next       = blinks_done;
    blinks_goal_next       = blinks_goal;
    phase_lit_next         = phase_lit;
    led_drive_next         = led_drive;

    if (error_class == slbc_pkg::CLASS_CRITICAL) begin
      led_drive_next   = 1'b1;
      phase_lit_next   = 1'b1;
      blinks_done_next = '0;
      blinks_goal_next = '0;
    end else if (since_inc >= per && blinks_done == '0) begin
      // burst start, a zero blink count just restarts the period
      blinks_goal_next       = sel_blinks;
      blinks_done_next       = '0;
      since_burst_start_next = '0;
      toggle_countdown_next  = sel_on;
      phase_lit_next         = (sel_blinks != '0);
      led_drive_next         = (sel_blinks != '0);
    end else if (blinks_goal != '0) begin
      toggle_countdown_next = cd_dec;
      if (cd_dec == '0) begin
        phase_lit_next        = ph_flip;
        led_drive_next        = ph_flip;
        toggle_countdown_next = ph_flip ? sel_on : sel_off;
        if (done_inc >= blinks_goal) begin
          blinks_goal_next = '0;
          blinks_done_next = '0;
          led_drive_next   = 1'b0;
        end else begin
          blinks_done_next = done_inc;
        end
      end
    end

    res_next.led_lit      = led_drive_next;
    res_next.burst_active = (blinks_goal_next != '0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      since_burst_start <= '0;
      toggle_countdown  <= '0;
      blinks_done       <= '0;
      blinks_goal       <= '0;
      phase_lit         <= 1'b0;
      led_drive         <= 1'b0;
    end else if (step) begin
      since_burst_start <= since_burst_start_next;
      toggle_countdown  <= toggle_countdown_next;
      blinks_done       <= blinks_done_next;
      blinks_goal       <= blinks_goal_next;
      phase_lit         <= phase_lit_next;
      led_drive         <= led_drive_next;
    end
  end

endmodule

`default_nettype wire

// ----- hdl/status_led_blink_coder.sv -----
// status_led_blink_coder: top level, input and result registers around the blink core
// depends on slbc_pkg, slbc_regs, slbc_core
//
//   channel | signals                          | direction | payload
//   --------+----------------------------------+-----------+---------------------------
//   in      | in_valid, in_stall               | sink      | error_class
//   out     | out_valid, out_stall             | source    | led_lit, burst_active
//   cfg     | cfg_valid, cfg_ready             | sink      | cfg_index, cfg_data
//
// one item per cycle while out is not stalled; an accepted tick sits in the
// input register, then the core update lands in the result register
// rst is synchronous: core blink state and led drive cleared, config regs to defaults
// a stall on out holds the result register; the input register still takes an
// item while its holder moves on, and in_stall rises only when both are full
// cfg_ready is always high, writes go straight into the register file
`default_nettype none

module status_led_blink_coder (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              in_valid,
  output logic                                   in_stall,
  input  wire logic [1:0]                        error_class,
  output logic                                   out_valid,
  input  wire logic                              out_stall,
  output logic                                   led_lit,
  output logic                                   burst_active,
  input  wire logic                              cfg_valid,
  output logic                                   cfg_ready,
  input  wire logic [slbc_pkg::CFG_IDX_BITS-1:0]  cfg_index,
  input  wire logic [slbc_pkg::CFG_DATA_BITS-1:0] cfg_data
);

  slbc_pkg::cfg_t    cfg;
  slbc_pkg::result_t res_next;

  // input register
  logic       s1_valid;
  logic [1:0] s1_class;
  logic       s1_move;   // held tick goes through the core into the result register
  logic       in_take;

  assign cfg_ready = 1'b1;

  // result register frees up when empty or drained this cycle
  assign s1_move  = s1_valid && (!out_valid || !out_stall);
  assign in_stall = s1_valid && !s1_move;
  assign in_take  = in_valid && !in_stall;

  slbc_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (cfg_valid && cfg_ready),
    .wr_idx  (cfg_index),
    .wr_data (cfg_data),
    .cfg     (cfg)
  );

  slbc_core u_core (
    .clk         (clk),
    .rst         (rst),
    .step        (s1_move),
    .error_class (s1_class),
    .cfg         (cfg),
    .res_next    (res_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_take) begin
      s1_valid <= 1'b1;
    end else if (s1_move) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_class <= error_class;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_move) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_move) begin
      led_lit      <= res_next.led_lit;
      burst_active <= res_next.burst_active;
    end
  end

  // a critical tick yields a steady lit led and no burst
  a_critical_lit: assert property (@(posedge clk) disable iff (rst)
    (s1_move && s1_class == slbc_pkg::CLASS_CRITICAL) |=>
      (out_valid && led_lit && !burst_active))
    else $error("critical tick did not light the led");

  // the input side only stalls while the input register holds an item and out is full and stalled
  a_stall_full: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> (s1_valid && out_valid && out_stall))
    else $error("input stalled with room downstream");

  // a tick that moves on always shows up as a result next cycle
  a_move_result: assert property (@(posedge clk) disable iff (rst)
    s1_move |=> out_valid)
    else $error("moved tick produced no result");

endmodule

`default_nettype wire
